### sv/majority_clocked_additive_keystream_unit_defines.svh
// Assertion macros for the keystream unit.
// Taken by the RTL files that carry concurrent checks; no other dependencies.
`ifndef MAJORITY_CLOCKED_ADDITIVE_KEYSTREAM_UNIT_DEFINES_SVH
`define MAJORITY_CLOCKED_ADDITIVE_KEYSTREAM_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent
`define MCAKS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mcaks: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent
`define MCAKS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mcaks: next-cycle check failed");
`else
`define MCAKS_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define MCAKS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### sv/mcaks_pkg.sv
// Package for the majority clocked additive keystream unit.
// Constants, generator geometry and the structs shared between modules; no dependencies.
`timescale 1ns / 1ps

package mcaks_pkg;

  localparam int NUM_GEN = 3;
  localparam int WORD_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int SEL_W   = 2;
  localparam int TAP_W   = 6;

  // Table lengths and initial second-tap positions
  localparam int LEN_A = 55;
  localparam int LEN_B = 57;
  localparam int LEN_C = 58;
  localparam int TAP_A = 31;
  localparam int TAP_B = 50;
  localparam int TAP_C = 39;

  localparam int GEN_LEN [NUM_GEN] = '{LEN_A, LEN_B, LEN_C};
  // A reset tap beyond its table reads modulo the length, so fold it once here
  localparam int GEN_TAP_RST [NUM_GEN] = '{TAP_A % LEN_A, TAP_B % LEN_B, TAP_C % LEN_C};

  // Action codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_CIPHER = 1'b1;

  // Table write request
  typedef struct packed {
    logic              en;
    logic [SEL_W-1:0]  sel;
    logic [TAP_W-1:0]  idx;
    logic [WORD_W-1:0] data;
  } wr_t;

  // Per-generator status towards the top level
  typedef struct packed {
    logic              carry;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] cand;
  } gen_st_t;

endpackage

### sv/mcaks_in_if.sv
// Input channel of the keystream unit: valid/ready plus one load or cipher item.
// Depends on mcaks_pkg.
`timescale 1ns / 1ps

interface mcaks_in_if import mcaks_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [SEL_W-1:0]  generator_select;
  logic [TAP_W-1:0]  word_index;
  logic [WORD_W-1:0] key_word;
  logic [BYTE_W-1:0] data_byte;

  modport source (
    output valid, action, generator_select, word_index, key_word, data_byte,
    input  ready
  );
  modport sink (
    input  valid, action, generator_select, word_index, key_word, data_byte,
    output ready
  );
endinterface

### sv/mcaks_out_if.sv
// Output channel of the keystream unit: valid/ready plus one transformed byte.
// Depends on mcaks_pkg.
`timescale 1ns / 1ps

interface mcaks_out_if import mcaks_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;

  modport source (
    output valid, out_byte,
    input  ready
  );
  modport sink (
    input  valid, out_byte,
    output ready
  );
endinterface

### sv/mcaks_ram.sv
// Generic RAM: one write port, two read ports, registered read data (old data on collision).
// No dependencies.
`timescale 1ns / 1ps

module mcaks_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

### sv/mcaks_gens.sv
// The three additive generators: word tables in RAM, taps, latest sum and carry.
// Depends on mcaks_pkg and mcaks_ram.
`timescale 1ns / 1ps

module mcaks_gens import mcaks_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  wr_t                        wr,
  input  logic [NUM_GEN-1:0]         step,
  output gen_st_t [NUM_GEN-1:0]      st
);

  logic [NUM_GEN-1:0] wr_ok;
  logic [NUM_GEN-1:0] fwd_en;
  logic [TAP_W-1:0]   fwd_idx;
  logic [WORD_W-1:0]  fwd_data;

  // Last cycle's write, to patch a read that raced it
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_en <= '0;
    end else begin
      fwd_en <= wr_ok;
    end
  end

  always_ff @(posedge clk) begin
    fwd_idx  <= wr.idx;
    fwd_data <= wr.data;
  end

  for (genvar g = 0; g < NUM_GEN; g++) begin : g_gen
    localparam int Len = GEN_LEN[g];
    localparam int Aw  = (Len > 1) ? $clog2(Len) : 1;

    logic [TAP_W-1:0]  tap1;
    logic [TAP_W-1:0]  tap2;
    logic [WORD_W-1:0] rd1;
    logic [WORD_W-1:0] rd2;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] s;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] sum;
    logic              carry;

    // Loads beyond the table or to a missing generator are dropped
    assign wr_ok[g] = wr.en && (wr.sel == SEL_W'(g))
                      && ({1'b0, wr.idx} < (TAP_W + 1)'(Len));

    // Tables are read at the current taps every cycle
    mcaks_ram #(
      .WIDTH (WORD_W),
      .DEPTH (Len)
    ) u_ram (
      .clk    (clk),
      .we     (wr_ok[g]),
      .waddr  (wr.idx[Aw-1:0]),
      .wdata  (wr.data),
      .raddr0 (tap1[Aw-1:0]),
      .raddr1 (tap2[Aw-1:0]),
      .rdata0 (rd1),
      .rdata1 (rd2)
    );

    // Forward a write that landed while the read was in flight
    assign x = (fwd_en[g] && (fwd_idx == tap1)) ? fwd_data : rd1;
    assign y = (fwd_en[g] && (fwd_idx == tap2)) ? fwd_data : rd2;

    // Candidate step result
    assign s  = x + y;
    assign lo = (x < y) ? x : y;

    always_ff @(posedge clk) begin
      if (rst) begin
        tap1  <= '0;
        tap2  <= TAP_W'(GEN_TAP_RST[g]);
        sum   <= '0;
        carry <= 1'b0;
      end else if (step[g]) begin
        tap1  <= (tap1 == TAP_W'(Len - 1)) ? '0 : tap1 + TAP_W'(1);
        tap2  <= (tap2 == TAP_W'(Len - 1)) ? '0 : tap2 + TAP_W'(1);
        sum   <= s;
        carry <= (lo > s);
      end
    end

    assign st[g].carry = carry;
    assign st[g].sum   = sum;
    assign st[g].cand  = s;
  end

endmodule

### sv/majority_clocked_additive_keystream_unit.sv
// Byte stream cipher with three majority clocked additive generators, top level.
// One item is taken per cycle unless the output or stale table reads hold it.
// A keystream word is drawn on every fourth cipher beat from the three generator
// tables, which are read at the current tap addresses ahead of use through
// registered RAM reads; input is held in the first cycle after reset, whatever
// the item, while those reads are stale. Apart from that cycle, loads and the three
// following cipher beats never wait on the tables. The output is a register:
// input is taken only when it is empty or being drained.
// The tables come up undefined and must be loaded before ciphering; there is no
// clearing pass. Depends on mcaks_pkg, the channel interfaces, mcaks_gens and
// majority_clocked_additive_keystream_unit_defines.svh.
`timescale 1ns / 1ps
`include "majority_clocked_additive_keystream_unit_defines.svh"

module majority_clocked_additive_keystream_unit import mcaks_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mcaks_in_if.sink    in_chan,
  mcaks_out_if.source out_chan
);

  logic                  fresh;
  logic [1:0]            bytes_left;
  logic [WORD_W-1:0]     keystream_word;
  logic                  out_valid;
  logic [BYTE_W-1:0]     out_byte;

  logic                  fire;
  logic                  cipher;
  logic                  do_word;
  logic                  maj;
  logic [NUM_GEN-1:0]    carry_vec;
  logic [NUM_GEN-1:0]    step;
  logic [WORD_W-1:0]     word_new;
  logic [WORD_W-1:0]     ks;
  logic [1:0]            pos;
  logic [BYTE_W-1:0]     kbyte;
  wr_t                   wr;
  gen_st_t [NUM_GEN-1:0] st;

  // Handshake: hold off while the output is full and not drained, or when a word is due and the table reads are stale
  assign in_chan.ready = (!out_valid || out_chan.ready) && ((bytes_left != 2'd0) || fresh);
  assign fire    = in_chan.valid && in_chan.ready;
  assign cipher  = fire && (in_chan.action == ACT_CIPHER);
  assign do_word = cipher && (bytes_left == 2'd0);

  // Table load request
  assign wr.en   = fire && (in_chan.action == ACT_LOAD);
  assign wr.sel  = in_chan.generator_select;
  assign wr.idx  = in_chan.word_index;
  assign wr.data = in_chan.key_word;

  mcaks_gens u_gens (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .step (step),
    .st   (st)
  );

  // Majority clocking
  always_comb begin
    for (int g = 0; g < NUM_GEN; g++) begin
      carry_vec[g] = st[g].carry;
    end
  end

  assign maj = (carry_vec[0] & carry_vec[1]) | (carry_vec[2] & (carry_vec[0] | carry_vec[1]));

  always_comb begin
    word_new = '0;
    for (int g = 0; g < NUM_GEN; g++) begin
      step[g]  = do_word && (carry_vec[g] == maj);
      word_new = word_new ^ (step[g] ? st[g].cand : st[g].sum);
    end
  end

  // Byte pick, least significant first
  assign ks    = do_word ? word_new : keystream_word;
  assign pos   = 2'(2'd0 - bytes_left);
  assign kbyte = ks[{pos, 3'b000} +: BYTE_W];

  // Keystream word, byte count and read freshness
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh          <= 1'b0;
      bytes_left     <= 2'd0;
      keystream_word <= '0;
    end else begin
      fresh <= !do_word;
      if (do_word) begin
        keystream_word <= word_new;
      end
      if (cipher) begin
        bytes_left <= do_word ? 2'd3 : bytes_left - 2'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cipher) begin
      out_valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cipher) begin
      out_byte <= in_chan.data_byte ^ kbyte;
    end
  end

  assign out_chan.valid    = out_valid;
  assign out_chan.out_byte = out_byte;

  // Checks
  `MCAKS_ASSERT_SAME(a_maj_steps, clk, rst, do_word, $countones(step) >= 2)
  `MCAKS_ASSERT_NEXT(a_word_refill, clk, rst, do_word, (bytes_left == 2'd3) && !fresh)
  `MCAKS_ASSERT_NEXT(a_cipher_result, clk, rst, cipher, out_valid)
  `MCAKS_ASSERT_NEXT(a_load_quiet, clk, rst, wr.en, $stable(bytes_left) && $stable(keystream_word))

endmodule

### verif/majority_clocked_additive_keystream_unit_tb.sv
// Testbench for majority_clocked_additive_keystream_unit: zero-fills the tables, runs directed
// rows, then random loads and cipher bytes checked against a local keystream predictor.
// Depends on mcaks_pkg, mcaks_in_if, mcaks_out_if and the unit itself.
`timescale 1ns / 1ps

module majority_clocked_additive_keystream_unit_tb;
  import mcaks_pkg::*;

  localparam logic [SEL_W-1:0] GEN_A    = 2'd0;
  localparam logic [SEL_W-1:0] GEN_B    = 2'd1;
  localparam logic [SEL_W-1:0] GEN_C    = 2'd2;
  localparam logic [SEL_W-1:0] GEN_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic              act;
    logic [SEL_W-1:0]  sel;
    logic [TAP_W-1:0]  idx;
    logic [WORD_W-1:0] word;
    logic [BYTE_W-1:0] data;
    logic              has_want;
    logic [BYTE_W-1:0] want;
  } key_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mcaks_in_if  in_chan ();
  mcaks_out_if out_chan ();

  majority_clocked_additive_keystream_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [WORD_W-1:0] key_tab [NUM_GEN][64];
  logic [TAP_W-1:0]  rd_ptr_x [NUM_GEN];
  logic [TAP_W-1:0]  rd_ptr_y [NUM_GEN];
  logic [WORD_W-1:0] gen_sum [NUM_GEN];
  logic              gen_carry [NUM_GEN];
  logic [WORD_W-1:0] ks_word;
  logic [2:0]        ks_bytes_left;

  logic [BYTE_W-1:0] pending_out_bytes [$];
  key_item_t         cur_item;
  int                fail_count = 0;
  int                cycle_count = 0;
  bit                quiet = 1'b0;

  function automatic key_item_t mk_item(logic act, logic [SEL_W-1:0] sel,
                                        logic [TAP_W-1:0] idx, logic [WORD_W-1:0] word,
                                        logic [BYTE_W-1:0] data, logic has_want,
                                        logic [BYTE_W-1:0] want);
    key_item_t it;
    it.act = act;
    it.sel = sel;
    it.idx = idx;
    it.word = word;
    it.data = data;
    it.has_want = has_want;
    it.want = want;
    return it;
  endfunction

  // Applies one accepted item to the predictor; a cipher byte yields its output byte
  task automatic predict_out_byte(input key_item_t it, output bit has_out,
                                  output logic [BYTE_W-1:0] out_b);
    logic              maj;
    logic [WORD_W-1:0] x, y, lo, s;
    logic [1:0]        pos;
    int                len;
    int                g;
    has_out = 1'b0;
    out_b = '0;
    if (it.act == ACT_LOAD) begin
      // Bad select or index past the table end: dropped
      if (it.sel != GEN_NONE) begin
        if (it.idx < GEN_LEN[it.sel]) key_tab[it.sel][it.idx] = it.word;
      end
    end else begin
      if (ks_bytes_left == 0) begin
        maj = (gen_carry[0] & gen_carry[1]) | (gen_carry[0] & gen_carry[2]) |
              (gen_carry[1] & gen_carry[2]);
        // Only generators agreeing with the majority carry step
        for (g = 0; g < NUM_GEN; g++) begin
          if (gen_carry[g] == maj) begin
            len = GEN_LEN[g];
            x = key_tab[g][rd_ptr_x[g]];
            y = key_tab[g][rd_ptr_y[g]];
            lo = (x < y) ? x : y;
            s = x + y;
            gen_sum[g] = s;
            gen_carry[g] = (lo > s);
            rd_ptr_x[g] = (rd_ptr_x[g] == len - 1) ? '0 : rd_ptr_x[g] + 1'b1;
            rd_ptr_y[g] = (rd_ptr_y[g] == len - 1) ? '0 : rd_ptr_y[g] + 1'b1;
          end
        end
        ks_word = gen_sum[0] ^ gen_sum[1] ^ gen_sum[2];
        ks_bytes_left = 3'd4;
      end
      // Bytes are spent least significant first
      pos = 2'(3'd4 - ks_bytes_left);
      out_b = it.data ^ ks_word[8*pos +: 8];
      ks_bytes_left = ks_bytes_left - 1'b1;
      has_out = 1'b1;
    end
  endtask

  function automatic key_item_t random_item();
    key_item_t   it;
    int          r;
    logic [1:0]  g;
    it = mk_item(ACT_CIPHER, 2'($urandom), 6'($urandom), $urandom, 8'($urandom), 1'b0, '0);
    r = $urandom_range(0, 99);
    if (r >= 60 && r < 90) begin
      g = 2'($urandom_range(0, 2));
      it.act = ACT_LOAD;
      it.sel = g;
      it.idx = 6'($urandom_range(0, GEN_LEN[g] - 1));
    end else if (r >= 90) begin
      // Load that the unit must drop
      it.act = ACT_LOAD;
      if ($urandom_range(0, 1) == 0) begin
        it.sel = GEN_NONE;
      end else begin
        g = 2'($urandom_range(0, 2));
        it.sel = g;
        it.idx = 6'($urandom_range(GEN_LEN[g], 63));
      end
    end
    return it;
  endfunction

  // Offer one beat after a random gap and hold it until taken
  task automatic send_item(input key_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid            <= 1'b1;
    in_chan.action           <= it.act;
    in_chan.generator_select <= it.sel;
    in_chan.word_index       <= it.idx;
    in_chan.key_word         <= it.word;
    in_chan.data_byte        <= it.data;
    cur_item                 <= it;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Predict on accepted inputs, check accepted outputs
  always @(posedge clk) begin
    bit                has_out;
    logic [BYTE_W-1:0] pred;
    logic [BYTE_W-1:0] want;
    if (!rst && in_chan.valid && in_chan.ready) begin
      predict_out_byte(cur_item, has_out, pred);
      if (has_out) pending_out_bytes.push_back(cur_item.has_want ? cur_item.want : pred);
    end
    if (!rst && out_chan.valid && out_chan.ready) begin
      if (pending_out_bytes.size() == 0) begin
        $display("%0t: out_byte %02h arrived with nothing expected", $time, out_chan.out_byte);
        fail_count++;
      end else begin
        want = pending_out_bytes.pop_front();
        if (out_chan.out_byte !== want) begin
          $display("%0t: out_byte expected %02h, actual %02h", $time, want, out_chan.out_byte);
          fail_count++;
        end
      end
    end
  end

  // Output back-pressure
  initial begin
    int stall;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Stimulus
  initial begin
    key_item_t directed_rows [$];
    key_item_t it;
    int        n;
    in_chan.valid            <= 1'b0;
    in_chan.action           <= ACT_LOAD;
    in_chan.generator_select <= GEN_A;
    in_chan.word_index       <= '0;
    in_chan.key_word         <= '0;
    in_chan.data_byte        <= '0;
    cur_item                 <= '0;
    for (int g = 0; g < NUM_GEN; g++) begin
      rd_ptr_x[g]  = '0;
      rd_ptr_y[g]  = TAP_W'(GEN_TAP_RST[g]);
      gen_sum[g]   = '0;
      gen_carry[g] = 1'b0;
      for (int i = 0; i < 64; i++) key_tab[g][i] = '0;
    end
    ks_word = '0;
    ks_bytes_left = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Every table entry written before any cipher beat; zeros keep the first keystream clear
    for (int g = 0; g < NUM_GEN; g++) begin
      for (int i = 0; i < GEN_LEN[g]; i++) begin
        send_item(mk_item(ACT_LOAD, 2'(g), 6'(i), '0, '0, 1'b0, '0));
      end
    end

    // All-zero tables: bytes pass through unchanged
    directed_rows.push_back(mk_item(ACT_CIPHER, GEN_A, 6'd0, '0, 8'h00, 1'b1, 8'h00));
    directed_rows.push_back(mk_item(ACT_CIPHER, GEN_A, 6'd0, '0, 8'hFF, 1'b1, 8'hFF));
    directed_rows.push_back(mk_item(ACT_CIPHER, GEN_A, 6'd0, '0, 8'hA5, 1'b1, 8'hA5));
    directed_rows.push_back(mk_item(ACT_CIPHER, GEN_A, 6'd0, '0, 8'h5A, 1'b1, 8'h5A));
    directed_rows.push_back(mk_item(ACT_CIPHER, GEN_A, 6'd0, '0, 8'h01, 1'b1, 8'h01));
    // Loads the unit must drop: bad select, index past each table's end
    directed_rows.push_back(mk_item(ACT_LOAD, GEN_NONE, 6'd63, 32'hFFFF_FFFF, '0, 1'b0, '0));
    directed_rows.push_back(mk_item(ACT_LOAD, GEN_A, 6'd55, 32'hFFFF_FFFF, '0, 1'b0, '0));
    directed_rows.push_back(mk_item(ACT_LOAD, GEN_B, 6'd57, 32'hFFFF_FFFF, '0, 1'b0, '0));
    directed_rows.push_back(mk_item(ACT_LOAD, GEN_C, 6'd58, 32'hFFFF_FFFF, '0, 1'b0, '0));
    directed_rows.push_back(mk_item(ACT_LOAD, GEN_C, 6'd63, 32'hFFFF_FFFF, '0, 1'b0, '0));
    directed_rows.push_back(mk_item(ACT_CIPHER, GEN_A, 6'd0, '0, 8'h80, 1'b1, 8'h80));
    directed_rows.push_back(mk_item(ACT_CIPHER, GEN_A, 6'd0, '0, 8'hC3, 1'b1, 8'hC3));
    directed_rows.push_back(mk_item(ACT_CIPHER, GEN_A, 6'd0, '0, 8'h3C, 1'b1, 8'h3C));
    // Words at the next tap positions: a wraps with carry, b wraps with carry, c does not
    directed_rows.push_back(mk_item(ACT_LOAD, GEN_A, 6'd2, 32'hFFFF_FFFF, '0, 1'b0, '0));
    directed_rows.push_back(mk_item(ACT_LOAD, GEN_A, 6'd33, 32'h0000_0001, '0, 1'b0, '0));
    directed_rows.push_back(mk_item(ACT_LOAD, GEN_B, 6'd2, 32'hFFFF_FFFF, '0, 1'b0, '0));
    directed_rows.push_back(mk_item(ACT_LOAD, GEN_B, 6'd52, 32'hFFFF_FFFF, '0, 1'b0, '0));
    directed_rows.push_back(mk_item(ACT_LOAD, GEN_C, 6'd2, 32'h8000_0000, '0, 1'b0, '0));
    directed_rows.push_back(mk_item(ACT_LOAD, GEN_C, 6'd41, 32'h7FFF_FFFF, '0, 1'b0, '0));
    // Next word, then one from the majority-clocked pair only
    for (int i = 0; i < 5; i++) begin
      directed_rows.push_back(mk_item(ACT_CIPHER, GEN_A, 6'd0, '0, 8'(i * 51), 1'b0, '0));
    end
    foreach (directed_rows[i]) send_item(directed_rows[i]);

    // Random loads and bytes; quiet stretches leave both sides without gaps
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      it = random_item();
      send_item(it);
      n++;
    end
    in_chan.valid <= 1'b0;

    while (pending_out_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
